>>> rtl/ssp_pkg.sv
package ssp_pkg;

    localparam int unsigned MAX_MICROSTEPS = 16384;

    localparam int POS_W    = 15;
    localparam int PERIOD_W = 16;
    localparam int CCW_W    = 2;
    localparam int CNT_W    = 16;
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 2;
    localparam int CFG_W    = 16;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SETPOS = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_REV    = 2'd0;
    localparam logic [IDX_W-1:0] REG_PERIOD = 2'd1;
    localparam logic [IDX_W-1:0] REG_CCW    = 2'd2;

    localparam logic [POS_W-1:0]    RESET_REV    = 15'd8000;
    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd8;
    localparam logic [CCW_W-1:0]    RESET_CCW    = 2'd2;

    localparam logic [POS_W-1:0] REV_MAX = POS_W'(MAX_MICROSTEPS);

    // effective (clamped) configuration
    typedef struct packed {
        logic [POS_W-1:0]    rev;
        logic [PERIOD_W-1:0] period;
        logic                ccw_two;   // 1: ccw steps need feedback edge pairs
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] target;
        logic             feedback_edge;
    } item_t;

    typedef struct packed {
        logic             step_pulse;
        logic             direction;
        logic             busy_res;
        logic [POS_W-1:0] position;
        logic             rejected;
    } res_t;

endpackage

>>> rtl/ssp_cfg_regs.sv
module ssp_cfg_regs (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [ssp_pkg::IDX_W-1:0] wr_index,
    input  logic [ssp_pkg::CFG_W-1:0] wr_data,
    output ssp_pkg::cfg_t           cfg
);
    import ssp_pkg::*;

    logic [POS_W-1:0]    rev_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [CCW_W-1:0]    ccw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_reg    <= RESET_REV;
            period_reg <= RESET_PERIOD;
            ccw_reg    <= RESET_CCW;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_REV:    rev_reg    <= wr_data[POS_W-1:0];
                REG_PERIOD: period_reg <= wr_data[PERIOD_W-1:0];
                REG_CCW:    ccw_reg    <= wr_data[CCW_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamp to usable ranges
    always_comb
    begin
        if (rev_reg < POS_W'(2))
            cfg.rev = POS_W'(2);
        else if (rev_reg > REV_MAX)
            cfg.rev = REV_MAX;
        else
            cfg.rev = rev_reg;
        cfg.period  = (period_reg < PERIOD_W'(2)) ? PERIOD_W'(2) : period_reg;
        cfg.ccw_two = ccw_reg[1];   // 0,1 -> single feedback edge per ccw step; 2,3 -> feedback edge pair
    end

endmodule

>>> rtl/ssp_step_core.sv
module ssp_step_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  ssp_pkg::item_t item,
    input  ssp_pkg::cfg_t  cfg,
    output ssp_pkg::res_t  res
);
    import ssp_pkg::*;

    localparam int SW = 20;   // signed work width for positions and deltas

    logic [POS_W-1:0] cur_pos_reg, cur_pos_next;
    logic [POS_W-1:0] goal_reg, goal_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] req_reg, req_next;
    logic [PERIOD_W-1:0] wave_reg, wave_next;
    logic cw_reg, cw_next;
    logic moving_reg, moving_next;

    logic is_pos_cmd, rej, do_tick, do_move, done, level, plan;
    logic [PERIOD_W-1:0] wave0;
    logic [PERIOD_W:0]   wave_inc;
    logic [CNT_W-1:0]    cnt1;
    logic signed [SW-1:0] m_s, pos_a, pos_b, d0, d1, d2;
    logic [POS_W-1:0]    plan_cur, plan_goal, tick_pos;
    logic [SW-1:0]       steps;
    logic [SW:0]         need;
    logic                plan_small;

    always_comb
    begin
        is_pos_cmd = (item.command == CMD_MOVE) || (item.command == CMD_SETPOS);
        rej        = is_pos_cmd && (moving_reg || (item.target > cfg.rev));
        do_tick    = (!is_pos_cmd || moving_reg) && moving_reg;
        do_move    = is_pos_cmd && !rej && (item.command == CMD_MOVE);
        m_s        = SW'($signed({1'b0, cfg.rev}));

        // square wave and edge count
        wave0    = (wave_reg >= cfg.period) ? '0 : wave_reg;
        level    = do_tick && (wave0 < (cfg.period >> 1));
        wave_inc = {1'b0, wave0} + (PERIOD_W+1)'(1);
        cnt1     = (item.feedback_edge && (cnt_reg != '1)) ? cnt_reg + CNT_W'(1) : cnt_reg;
        done     = do_tick && (cnt1 >= req_reg);

        // position after a finished segment
        if (cw_reg)
            pos_a = $signed({5'b0, cur_pos_reg}) + $signed({4'b0, cnt1});
        else
            pos_a = $signed({5'b0, cur_pos_reg})
                  - $signed({4'b0, (cfg.ccw_two ? (cnt1 >> 1) : cnt1)});
        if (pos_a > m_s)
            pos_b = pos_a - m_s;
        else if (pos_a < 0)
            pos_b = pos_a + m_s;
        else
            pos_b = pos_a;
        tick_pos = (pos_b < 0) ? '0 : pos_b[POS_W-1:0];

        // shared segment planner
        plan      = done || do_move;
        plan_cur  = done ? tick_pos : cur_pos_reg;
        plan_goal = do_move ? item.target : goal_reg;
        d0 = $signed({5'b0, plan_goal}) - $signed({5'b0, plan_cur});
        d1 = d0 <<< 1;
        if (d1 > m_s)
            d2 = d0 - m_s;
        else if (d1 < -m_s)
            d2 = d0 + m_s;
        else
            d2 = d0;
        plan_small = (d2 >= -1) && (d2 <= 1);
        steps = (d2 < 0) ? SW'(-d2) : SW'(d2);
        need  = (d2 > 0 || !cfg.ccw_two) ? {1'b0, steps} : {steps, 1'b0};

        cur_pos_next = cur_pos_reg;
        goal_next    = goal_reg;
        cnt_next     = cnt_reg;
        req_next     = req_reg;
        wave_next    = wave_reg;
        cw_next      = cw_reg;
        moving_next  = moving_reg;

        if (do_tick)
        begin
            wave_next = (wave_inc >= {1'b0, cfg.period}) ? '0 : wave_inc[PERIOD_W-1:0];
            cnt_next  = cnt1;
        end
        if (done)
            cur_pos_next = tick_pos;
        if (do_move)
            goal_next = item.target;
        if (is_pos_cmd && !rej && (item.command == CMD_SETPOS))
            cur_pos_next = item.target;
        if (plan)
        begin
            if (plan_small)
                moving_next = 1'b0;
            else
            begin
                cw_next     = d2 > 0;
                req_next    = (need > (SW+1)'(16'hFFFF)) ? '1 : need[CNT_W-1:0];
                cnt_next    = '0;
                wave_next   = '0;
                moving_next = 1'b1;
            end
        end

        res.step_pulse = level;
        res.direction  = cw_next;
        res.busy_res   = moving_next;
        res.position   = cur_pos_next;
        res.rejected   = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg <= '0;
            goal_reg    <= '0;
            cnt_reg     <= '0;
            req_reg     <= '0;
            wave_reg    <= '0;
            cw_reg      <= 1'b0;
            moving_reg  <= 1'b0;
        end
        else if (fire)
        begin
            cur_pos_reg <= cur_pos_next;
            goal_reg    <= goal_next;
            cnt_reg     <= cnt_next;
            req_reg     <= req_next;
            wave_reg    <= wave_next;
            cw_reg      <= cw_next;
            moving_reg  <= moving_next;
        end
    end

endmodule

>>> rtl/stepper_shortest_path_positioner.sv
// Stepper positioner, shortest path in whole microsteps.
// Items pass through the input register, then the step core writes its state and
// the result register together when the item advances.
// Throughput: one item per cycle unless the receiver stalls the result register.
// Reset (rst_n, async, active low): position, goal, counters and flags clear,
// registers return to 8000 microsteps/rev, period 8, two ccw edges per step.
module stepper_shortest_path_positioner (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [14:0] target, [15] feedback_edge
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] step_pulse, [1] direction, [2] busy_res,
                                   // [17:3] position, [18] rejected, [23:19] zero
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ssp_pkg::*;

    cfg_t  cfg;
    item_t in_reg;
    logic  in_valid_reg;
    res_t  out_reg;
    res_t  core_res;
    logic  out_valid_reg;
    logic  advance;

    // config is always writable; the core only samples it when an item fires
    assign cfg_ready = 1'b1;

    ssp_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // an item in the input register moves on when the result slot is free
    // or being emptied this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.command       <= s_tuser;
            in_reg.target        <= s_tdata[14:0];
            in_reg.feedback_edge <= s_tdata[15];
        end
    end

    ssp_step_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= core_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.rejected, out_reg.position, out_reg.busy_res,
                       out_reg.direction, out_reg.step_pulse};

endmodule

>>> rtl/ssp_checker.sv
module ssp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    logic             last_busy_reg;
    logic [14:0]      last_pos_reg;
    logic             out_hs;

    assign out_hs = m_tvalid && m_tready;

    // busy flag and position of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_busy_reg <= 1'b0;
            last_pos_reg  <= '0;
        end
        else if (out_hs)
        begin
            last_busy_reg <= m_tdata[2];
            last_pos_reg  <= m_tdata[17:3];
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a step level only comes out of a move already under way
    a_step_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_hs && m_tdata[0] |-> last_busy_reg)
        else $error("step pulse while idle");

    // a refused command while idle changes nothing
    a_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_hs && m_tdata[18] && !last_busy_reg |->
            !m_tdata[2] && (m_tdata[17:3] == last_pos_reg) && !m_tdata[0])
        else $error("rejected idle command changed state");

endmodule

bind stepper_shortest_path_positioner ssp_checker u_ssp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> verif/positioner_checker.sv
module positioner_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [15:0]                s_tdata,   // [14:0] target, [15] feedback_edge
    input  logic [1:0]                 s_tuser,   // [1:0] command
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [23:0]                m_tdata,   // [0] step, [1] dir, [2] busy,
                                                  // [17:3] pos, [18] rej
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [ssp_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ssp_pkg::CFG_W-1:0]  cfg_data,
    output int unsigned                fail_count,
    output int unsigned                outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import ssp_pkg::*;

    // shadow copy of registers and motion state
    logic [POS_W-1:0]    rev_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [CCW_W-1:0]    ccw_reg;
    int                  cur_pos;
    int                  goal_pos;
    int unsigned         edges_seen;
    int unsigned         edges_needed;
    int unsigned         wave_pos;
    bit                  turning_cw;
    bit                  in_motion;

    res_t        reports_due[$];
    int unsigned mismatches = 0;

    assign fail_count = mismatches;

    function automatic int rev_used();
        if (rev_reg < 2) return 2;
        if (rev_reg > MAX_MICROSTEPS) return MAX_MICROSTEPS;
        return int'(rev_reg);
    endfunction

    function automatic int unsigned period_used();
        return (period_reg < 2) ? 2 : int'(period_reg);
    endfunction

    function automatic int unsigned ccw_used();
        if (ccw_reg == 0) return 1;
        if (ccw_reg > 2) return 2;
        return int'(ccw_reg);
    endfunction

    // next leg toward goal; stops when within one microstep
    function automatic void plan_leg();
        int          m;
        int          d;
        int unsigned steps;
        int unsigned need;
        m = rev_used();
        d = goal_pos - cur_pos;
        if (2 * d > m) d -= m;
        else if (2 * d < -m) d += m;
        if (d >= -1 && d <= 1) begin
            in_motion = 1'b0;
            return;
        end
        turning_cw = (d > 0);
        steps      = (d > 0) ? d : -d;
        need       = turning_cw ? steps : steps * ccw_used();
        if (need > 65535) need = 65535;
        edges_needed = need;
        edges_seen   = 0;
        wave_pos     = 0;
        in_motion    = 1'b1;
    endfunction

    // one tick of the step wave; returns the step level
    function automatic bit run_tick(bit fb);
        int unsigned p;
        int          m;
        int          pos;
        bit          level;
        if (!in_motion) return 1'b0;
        p = period_used();
        if (wave_pos >= p) wave_pos = 0;
        level    = (wave_pos < (p >> 1));
        wave_pos = (wave_pos + 1 >= p) ? 0 : wave_pos + 1;
        if (fb && edges_seen < 65535) edges_seen++;
        if (edges_seen >= edges_needed) begin
            m   = rev_used();
            pos = cur_pos;
            if (turning_cw) pos += int'(edges_seen);
            else pos -= int'(edges_seen / ccw_used());
            if (pos > m) pos -= m;
            else if (pos < 0) pos += m;
            if (pos < 0) pos = 0;
            cur_pos = pos & 32'h7FFF;
            plan_leg();
        end
        return level;
    endfunction

    function automatic res_t predict_motor_report(item_t cmd_item);
        res_t r;
        bit   level;
        bit   refused;
        level   = 1'b0;
        refused = 1'b0;
        if (cmd_item.command == CMD_MOVE || cmd_item.command == CMD_SETPOS) begin
            if (in_motion) begin
                refused = 1'b1;
                level   = run_tick(cmd_item.feedback_edge);
            end
            else if (int'(cmd_item.target) > rev_used()) begin
                refused = 1'b1;
            end
            else if (cmd_item.command == CMD_MOVE) begin
                goal_pos = int'(cmd_item.target);
                plan_leg();
            end
            else begin
                cur_pos = int'(cmd_item.target);
            end
        end
        else begin
            level = run_tick(cmd_item.feedback_edge);
        end
        r.step_pulse = level;
        r.direction  = turning_cw;
        r.busy_res   = in_motion;
        r.position   = cur_pos[POS_W-1:0];
        r.rejected   = refused;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        res_t  got;
        res_t  want;
        item_t cmd_item;
        if (!rst_n) begin
            rev_reg      = RESET_REV;
            period_reg   = RESET_PERIOD;
            ccw_reg      = RESET_CCW;
            cur_pos      = 0;
            goal_pos     = 0;
            edges_seen   = 0;
            edges_needed = 0;
            wave_pos     = 0;
            turning_cw   = 1'b0;
            in_motion    = 1'b0;
            reports_due.delete();
            outstanding <= 0;
        end
        else begin
            // results first: an item accepted now cannot be answered yet
            if (m_tvalid && m_tready) begin
                got.step_pulse = m_tdata[0];
                got.direction  = m_tdata[1];
                got.busy_res   = m_tdata[2];
                got.position   = m_tdata[17:3];
                got.rejected   = m_tdata[18];
                if (reports_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected report step=%0b dir=%0b busy=%0b pos=%0d rej=%0b",
                                 $time, got.step_pulse, got.direction, got.busy_res,
                                 got.position, got.rejected);
                    mismatches++;
                end
                else begin
                    want = reports_due.pop_front();
                    if (got.step_pulse !== want.step_pulse || got.direction !== want.direction
                        || got.busy_res !== want.busy_res || got.position !== want.position
                        || got.rejected !== want.rejected) begin
                        if (mismatches < 10) begin
                            $display("%0t: report differs", $time);
                            $display("  exp step=%0b dir=%0b busy=%0b pos=%0d rej=%0b",
                                     want.step_pulse, want.direction, want.busy_res,
                                     want.position, want.rejected);
                            $display("  got step=%0b dir=%0b busy=%0b pos=%0d rej=%0b",
                                     got.step_pulse, got.direction, got.busy_res,
                                     got.position, got.rejected);
                        end
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_REV:    rev_reg    = cfg_data[POS_W-1:0];
                    REG_PERIOD: period_reg = cfg_data[PERIOD_W-1:0];
                    REG_CCW:    ccw_reg    = cfg_data[CCW_W-1:0];
                    default:    ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                cmd_item.command       = s_tuser;
                cmd_item.target        = s_tdata[14:0];
                cmd_item.feedback_edge = s_tdata[15];
                reports_due.push_back(predict_motor_report(cmd_item));
            end
            outstanding <= reports_due.size();
        end
    end

endmodule

>>> verif/tb_stepper_shortest_path_positioner.sv
module tb_stepper_shortest_path_positioner;

    timeunit 1ns;
    timeprecision 1ps;

    import ssp_pkg::*;

    // the spare command code acts as a plain tick
    localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;
    localparam int unsigned      CYCLE_LIMIT = 400_000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;    // [14:0] target, [15] feedback_edge
    logic [1:0]        s_tuser   = '0;    // [1:0] command
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;           // [0] step, [1] dir, [2] busy, [17:3] pos, [18] rej
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;     // chance per cycle the sender sits out
    int unsigned stall_pct     = 0;     // chance per cycle the receiver stalls
    int unsigned rev_now       = 8000;  // effective microsteps/rev, for target picks

    always #5 clk = ~clk;

    stepper_shortest_path_positioner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    positioner_checker u_positioner_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // receiver backpressure; stall_pct changes only by NBA so this block
    // always sees the value from the previous edge
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stepper_shortest_path_positioner: mismatch");
            $finish;
        end
    end

    // One input item. A random gap (valid low) goes in front when the sender
    // is idling; with no gap valid simply stays high from the previous item.
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] tgt,
                             input logic fb);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {fb, tgt};
        do @(posedge clk); while (!s_tready);
    endtask

    // one register beat; valid is left high for the caller to drop
    task automatic cfg_beat(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] rev, input logic [CFG_W-1:0] per,
                                input logic [CFG_W-1:0] ccw);
        cfg_beat(REG_REV, rev);
        cfg_beat(REG_PERIOD, per);
        cfg_beat(REG_CCW, ccw);
        cfg_valid <= 1'b0;
        // block clamps rev to 2..MAX_MICROSTEPS
        rev_now = int'(rev[POS_W-1:0]);
        if (rev_now < 2) rev_now = 2;
        if (rev_now > MAX_MICROSTEPS) rev_now = MAX_MICROSTEPS;
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (6) @(posedge clk);
    endtask

    // Mostly move sequences: optional calibration, a move toward a nearby
    // (large rev) or any (small rev) target, then a run of ticks with
    // feedback edges most of the time. Commands sprinkled into the run hit
    // the busy rejection. The rest is raw noise over all command codes and
    // all target bits, including targets above one revolution.
    task automatic motor_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned base;
        int unsigned target;
        int unsigned span;
        int unsigned ticks;
        int unsigned pick;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 80) begin
                span = (rev_now <= 64) ? rev_now / 2 + 1 : 12;
                base = $urandom_range(0, rev_now);
                if ($urandom_range(0, 1)) begin
                    push_item(CMD_SETPOS, POS_W'(base), 1'($urandom_range(0, 1)));
                    sent++;
                end
                if (rev_now <= 64)
                    target = $urandom_range(0, rev_now);
                else
                    target = (base + rev_now + $urandom_range(0, 24) - 12) % rev_now;
                push_item(CMD_MOVE, POS_W'(target), 1'($urandom_range(0, 1)));
                sent++;
                // roughly enough edges for the leg, sometimes short of it
                ticks = $urandom_range(2, 3 * span + 6);
                repeat (ticks) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 4)
                        push_item($urandom_range(0, 1) ? CMD_MOVE : CMD_SETPOS,
                                  POS_W'($urandom_range(0, rev_now)),
                                  1'($urandom_range(0, 1)));
                    else if (pick < 7)
                        push_item(CMD_SPARE, POS_W'($urandom_range(0, 32767)),
                                  1'($urandom_range(0, 1)));
                    else
                        push_item(CMD_TICK, POS_W'($urandom_range(0, 32767)),
                                  $urandom_range(0, 99) < 85);
                    sent++;
                end
            end
            else begin
                push_item(CMD_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 32767)),
                          1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] rev, input logic [CFG_W-1:0] per,
                             input logic [CFG_W-1:0] ccw, input int unsigned idle,
                             input int unsigned stall, input int unsigned count);
        write_config(rev, per, ccw);
        send_idle_pct = idle;
        stall_pct    <= stall;
        motor_traffic(count);
        drain();
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass on reset settings: 8000 microsteps, period 8, two
        // ccw edges per step. No idling here.
        push_item(CMD_TICK, 0, 1'b1);           // tick while idle
        push_item(CMD_SPARE, 32767, 1'b1);      // spare code while idle
        push_item(CMD_MOVE, 8001, 1'b0);        // target above one rev
        push_item(CMD_SETPOS, 16384, 1'b1);     // calibration above one rev
        push_item(CMD_SETPOS, 8000, 1'b0);      // exactly one rev is legal
        push_item(CMD_MOVE, 1, 1'b0);           // wraps to +1: too small to move
        push_item(CMD_MOVE, 7999, 1'b0);        // -1: too small
        push_item(CMD_SETPOS, 0, 1'b0);
        push_item(CMD_MOVE, 3, 1'b1);           // cw leg of 3
        push_item(CMD_MOVE, 5, 1'b1);           // busy: refused, still a tick
        push_item(CMD_SETPOS, 9, 1'b1);         // busy: refused, edge still counts
        push_item(CMD_TICK, 0, 1'b1);           // this feedback edge completes the cw leg
        push_item(CMD_MOVE, 7998, 1'b0);        // ccw 5 across zero, feedback edge pair per step
        repeat (10) push_item(CMD_TICK, 0, 1'b1);
        push_item(CMD_SPARE, 0, 1'b1);
        drain();

        // rev, period, ccw, sender idle %, receiver stall %, items
        run_phase(16,    2,     1, 0,  0,  110);
        run_phase(32767, 65535, 3, 66, 0,  110);   // rev clamps to max, ccw 3 acts as 2
        run_phase(0,     0,     0, 0,  66, 40);    // all clamp low
        run_phase(40,    3,     2, 32, 32, 120);
        run_phase(8000,  8,     2, 0,  0,  110);
        run_phase(24,    5,     1, 66, 0,  110);
        run_phase(60,    7,     2, 0,  66, 100);
        run_phase(16384, 4,     1, 32, 32, 120);
        run_phase(9,     11,    2, 0,  0,  100);

        if (fail_count == 0)
            $display("stepper_shortest_path_positioner: match");
        else
            $display("stepper_shortest_path_positioner: mismatch");
        $finish;
    end

endmodule
